@@ rtl/oasu_pkg.sv @@
// ----------------------------------------------------------------------------
// oasu_pkg
// Shared types, constants and the sine table generator for the oscillator
// and envelope sample unit.
// ----------------------------------------------------------------------------
package oasu_pkg;

   // Default build parameters
   localparam int unsigned SINE_TABLE_DEPTH_DEF = 256;
   localparam int unsigned PHASE_BITS_DEF       = 24;

   // Fixed field widths
   localparam int unsigned FREQ_W   = 24;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned LEN_W    = 31;
   localparam int unsigned SEG_W    = 31;
   localparam int unsigned LEVEL_W  = 17;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned WAVE_W   = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned WMAG_W   = 16;
   localparam int unsigned FRAC_W   = 24;

   // Envelope and waveform constants
   localparam logic [SEG_W-1:0]    MIN_SEGMENT  = 31'd7;
   localparam logic [LEVEL_W-1:0]  FULL_SCALE   = 17'd65536;
   localparam logic [WMAG_W-1:0]   SQUARE_LEVEL = 16'd26214;
   localparam logic [63:0]         HALF_PI_Q30  = 64'd1686629713;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WAVEFORM = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSTAIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE  = 3'd4;

   // Waveform codes
   localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd0;
   localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd1;
   localparam logic [WAVE_W-1:0] WAVE_SAW      = 3'd2;
   localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd3;

   // Envelope segment of one item
   typedef enum logic [2:0] {
      SEG_ZERO,
      SEG_ATTACK,
      SEG_DECAY,
      SEG_SUSTAIN,
      SEG_RELEASE
   } seg_type;

   // Sideband carried alongside the divider
   typedef struct packed {
      seg_type             seg;
      logic [LEVEL_W-1:0]  sus;
      logic [WMAG_W-1:0]   wmag;
      logic                wneg;
   } side_type;

   // round(32768 * sin(x)) for x in [0, pi/2], x in Q30; elaboration only
   function automatic logic [15:0] sine_entry(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [63:0] sum;
      logic [63:0] rnd;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int k = 1; k <= 7; k++) begin
         term = (term * x2) >> 30;
         term = term / 64'((2 * k) * (2 * k + 1));
         if ((k % 2) == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      rnd = ($unsigned(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
      return rnd[15:0];
   endfunction

endpackage

@@ rtl/oasu_div.sv @@
// ----------------------------------------------------------------------------
// oasu_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// word and a valid bit travelling alongside. The caller guarantees that the
// quotient fits in QUOT_W bits.
// ----------------------------------------------------------------------------
module oasu_div
   import oasu_pkg::*;
#(
   parameter int unsigned DEN_W  = 31,
   parameter int unsigned QUOT_W = 17,
   parameter int unsigned SIDE_W = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic [DEN_W+QUOT_W-1:0]   in_num,
   input  logic [DEN_W-1:0]          in_den,
   input  logic [SIDE_W-1:0]         in_side,
   output logic                      out_valid,
   output logic [QUOT_W-1:0]         out_quot,
   output logic [SIDE_W-1:0]         out_side
);

   logic [DEN_W-1:0]  rem_ff  [QUOT_W];
   logic [QUOT_W-1:0] wrd_ff  [QUOT_W];
   logic [DEN_W-1:0]  den_ff  [QUOT_W];
   logic [SIDE_W-1:0] side_ff [QUOT_W];
   logic              vld_ff  [QUOT_W];

   for (genvar k = 0; k < QUOT_W; k++) begin : g_step
      logic [DEN_W-1:0]  rem_prev;
      logic [QUOT_W-1:0] wrd_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              vld_prev;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;
      logic [QUOT_W-1:0] wrd_in;

      // pick the previous stage or the input beat
      if (k == 0) begin : g_first
         assign rem_prev  = in_num[DEN_W+QUOT_W-1:QUOT_W];
         assign wrd_prev  = in_num[QUOT_W-1:0];
         assign den_prev  = in_den;
         assign side_prev = in_side;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign wrd_prev  = wrd_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      // trial subtract of one quotient bit
      always_comb begin
         trial  = {rem_prev, wrd_prev[QUOT_W-1]};
         diff   = trial - {1'b0, den_prev};
         ge     = (trial >= {1'b0, den_prev});
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         wrd_in = {wrd_prev[QUOT_W-2:0], ge};
      end

      // advance the stage
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_prev;
         end
         if (advance) begin
            rem_ff[k]  <= rem_in;
            wrd_ff[k]  <= wrd_in;
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[QUOT_W-1];
   assign out_quot  = wrd_ff[QUOT_W-1];
   assign out_side  = side_ff[QUOT_W-1];

endmodule

@@ rtl/oscillator_adsr_sample_unit.sv @@
// ----------------------------------------------------------------------------
// oscillator_adsr_sample_unit
// One audio sample per beat: linear ADSR envelope times a selected waveform.
// ----------------------------------------------------------------------------
// Each request beat carries a frequency, the time since note start and the
// note length; each response beat carries the sample and the envelope level.
// The unit keeps no state between beats and takes one beat per cycle
// unless the response stalls. Each beat passes three front stages (segment
// decode, the two multipliers, waveform and sine table read), 17 stages of
// the envelope divider (one quotient bit each), then envelope, gain multiply
// and saturation stages. A stalled response holds the whole pipeline.
// Configuration is written via csr_ while idle: a user duty, not enforced.
module oscillator_adsr_sample_unit
   import oasu_pkg::*;
#(
   parameter int unsigned SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
   parameter int unsigned PHASE_BITS       = PHASE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request: frequency[23:0], elapsed_time[55:24], note_length[86:56]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [87:0]           req_tdata,
   // response: sample[15:0], envelope_level[32:16]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SEG_W-1:0]      csr_wdata
);

   localparam int unsigned IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int unsigned QB     = PHASE_BITS - 2;
   localparam int unsigned QUOT_W = LEVEL_W;
   localparam int unsigned NUM_W  = SEG_W + QUOT_W;
   localparam int unsigned SIDE_W = $bits(side_type);

   // ---------------- configuration registers ----------------
   logic [WAVE_W-1:0]  wave_sel_ff;
   logic [SEG_W-1:0]   attack_ff;
   logic [SEG_W-1:0]   decay_ff;
   logic [LEVEL_W-1:0] sustain_ff;
   logic [SEG_W-1:0]   release_ff;

   // take a register write
   always_ff @(posedge clock) begin
      if (reset) begin
         wave_sel_ff <= WAVE_SINE;
         attack_ff   <= 31'd655;
         decay_ff    <= 31'd655;
         sustain_ff  <= FULL_SCALE;
         release_ff  <= 31'd655;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WAVEFORM: wave_sel_ff <= csr_wdata[WAVE_W-1:0];
            CSR_ATTACK:   attack_ff   <= csr_wdata;
            CSR_DECAY:    decay_ff    <= csr_wdata;
            CSR_SUSTAIN:  sustain_ff  <= csr_wdata[LEVEL_W-1:0];
            CSR_RELEASE:  release_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- handshake ----------------
   logic advance;
   logic rsp_valid_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // ---------------- stage A: segment decode ----------------
   logic [FREQ_W-1:0]  in_freq;
   logic [TIME_W-1:0]  in_time;
   logic [LEN_W-1:0]   in_len;
   logic [SEG_W-1:0]   a_cl;
   logic [SEG_W-1:0]   d_cl;
   logic [SEG_W-1:0]   r_cl;
   logic [LEVEL_W-1:0] s_cl;
   logic [SEG_W-1:0]   t_val;
   logic [SEG_W:0]     dend;
   logic [SEG_W:0]     send;
   logic [SEG_W:0]     e_val;
   seg_type            seg_in;
   logic [LEVEL_W-1:0] opa_in;
   logic [SEG_W-1:0]   opb_in;
   logic [SEG_W-1:0]   den_in;

   assign in_freq = req_tdata[23:0];
   assign in_time = req_tdata[55:24];
   assign in_len  = req_tdata[86:56];

   always_comb begin
      a_cl   = (attack_ff  < MIN_SEGMENT) ? MIN_SEGMENT : attack_ff;
      d_cl   = (decay_ff   < MIN_SEGMENT) ? MIN_SEGMENT : decay_ff;
      r_cl   = (release_ff < MIN_SEGMENT) ? MIN_SEGMENT : release_ff;
      s_cl   = (sustain_ff > FULL_SCALE) ? FULL_SCALE : sustain_ff;
      t_val  = in_time[SEG_W-1:0];
      dend   = {1'b0, a_cl} + {1'b0, d_cl};
      send   = ({1'b0, in_len} > dend) ? {1'b0, in_len} : dend;
      e_val  = {1'b0, t_val} - send;
      seg_in = SEG_ZERO;
      opa_in = '0;
      opb_in = '0;
      den_in = MIN_SEGMENT;
      if (in_time[TIME_W-1]) begin
         seg_in = SEG_ZERO;
      end else if (t_val < a_cl) begin
         seg_in = SEG_ATTACK;
         opa_in = FULL_SCALE;
         opb_in = t_val;
         den_in = a_cl;
      end else if ({1'b0, t_val} < dend) begin
         seg_in = SEG_DECAY;
         opa_in = FULL_SCALE - s_cl;
         opb_in = t_val - a_cl;
         den_in = d_cl;
      end else if ({1'b0, t_val} < send) begin
         seg_in = SEG_SUSTAIN;
      end else if (e_val < {1'b0, r_cl}) begin
         seg_in = SEG_RELEASE;
         opa_in = s_cl;
         opb_in = r_cl - e_val[SEG_W-1:0];
         den_in = r_cl;
      end
   end

   logic               vld_a_ff;
   seg_type            seg_a_ff;
   logic [LEVEL_W-1:0] opa_a_ff;
   logic [SEG_W-1:0]   opb_a_ff;
   logic [SEG_W-1:0]   den_a_ff;
   logic [LEVEL_W-1:0] sus_a_ff;
   logic [FREQ_W-1:0]  freq_a_ff;
   logic [FRAC_W-1:0]  tlo_a_ff;

   // ---------------- stage B: multipliers ----------------
   logic               vld_b_ff;
   seg_type            seg_b_ff;
   logic [NUM_W-1:0]   num_b_ff;
   logic [SEG_W-1:0]   den_b_ff;
   logic [LEVEL_W-1:0] sus_b_ff;
   logic [FRAC_W-1:0]  frac_b_ff;
   logic [NUM_W-1:0]   num_b_in;
   logic [2*FRAC_W-1:0] fprod;

   assign num_b_in = NUM_W'(opa_a_ff) * NUM_W'(opb_a_ff);
   assign fprod    = (2*FRAC_W)'(freq_a_ff) * (2*FRAC_W)'(tlo_a_ff);

   // ---------------- stage C: waveform and sine table ----------------
   logic [PHASE_BITS-1:0]    phase;
   logic [PHASE_BITS+14:0]   phase_ext;
   logic [14:0]              fpos;
   logic [QB+IDX_W-1:0]      idx_prod;
   logic [IDX_W-1:0]         idx_raw;
   logic [IDX_W-1:0]         idx_sel;
   logic [WMAG_W-1:0]        sine_rom [SINE_TABLE_DEPTH+1];
   logic [16:0]              saw_mag;
   logic [14:0]              tri_g;
   logic [17:0]              tri_4g;
   logic [17:0]              tri_mag;
   logic [WMAG_W-1:0]        wmag_c_in;
   logic                     wneg_c_in;

   // build the quarter-wave sine table at elaboration
   for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_sine
      localparam logic [WMAG_W-1:0] SineVal =
         sine_entry((HALF_PI_Q30 * 64'(gi)) / SINE_TABLE_DEPTH);
      assign sine_rom[gi] = SineVal;
   end

   // scale the 24-bit fraction to the phase width
   if (PHASE_BITS <= FRAC_W) begin : g_ph_trunc
      assign phase = frac_b_ff[FRAC_W-1:FRAC_W-PHASE_BITS];
   end else begin : g_ph_shift
      assign phase = {frac_b_ff, {(PHASE_BITS-FRAC_W){1'b0}}};
   end

   always_comb begin
      phase_ext = {phase, 15'd0};
      fpos      = phase_ext[PHASE_BITS+14:PHASE_BITS];
      idx_prod  = (QB+IDX_W)'(phase[QB-1:0]) * (QB+IDX_W)'(SINE_TABLE_DEPTH);
      idx_raw   = idx_prod[QB+IDX_W-1:QB];
      idx_sel   = phase[QB] ? IDX_W'(SINE_TABLE_DEPTH) - idx_raw : idx_raw;
      saw_mag   = fpos[14] ? {1'b0, fpos, 1'b0} - 17'd32768
                           : 17'd32768 - {1'b0, fpos, 1'b0};
      tri_g     = fpos[14] ? fpos - 15'd16384 : 15'd16384 - fpos;
      tri_4g    = {1'b0, tri_g, 2'b00};
      tri_mag   = (tri_4g >= 18'd32768) ? tri_4g - 18'd32768 : 18'd32768 - tri_4g;
      case (wave_sel_ff)
         WAVE_SINE: begin
            wmag_c_in = sine_rom[idx_sel];
            wneg_c_in = phase[PHASE_BITS-1];
         end
         WAVE_SQUARE: begin
            wmag_c_in = SQUARE_LEVEL;
            wneg_c_in = phase[PHASE_BITS-1];
         end
         WAVE_SAW: begin
            wmag_c_in = saw_mag[WMAG_W-1:0];
            wneg_c_in = !fpos[14];
         end
         WAVE_TRIANGLE: begin
            wmag_c_in = tri_mag[WMAG_W-1:0];
            wneg_c_in = (tri_4g < 18'd32768);
         end
         default: begin
            wmag_c_in = '0;
            wneg_c_in = 1'b0;
         end
      endcase
   end

   logic               vld_c_ff;
   logic [NUM_W-1:0]   num_c_ff;
   logic [SEG_W-1:0]   den_c_ff;
   side_type           side_c_ff;

   // advance the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
      end else if (advance) begin
         vld_a_ff <= req_tvalid;
         vld_b_ff <= vld_a_ff;
         vld_c_ff <= vld_b_ff;
      end
      if (advance) begin
         seg_a_ff  <= seg_in;
         opa_a_ff  <= opa_in;
         opb_a_ff  <= opb_in;
         den_a_ff  <= den_in;
         sus_a_ff  <= s_cl;
         freq_a_ff <= in_freq;
         tlo_a_ff  <= in_time[FRAC_W-1:0];
         seg_b_ff  <= seg_a_ff;
         num_b_ff  <= num_b_in;
         den_b_ff  <= den_a_ff;
         sus_b_ff  <= sus_a_ff;
         frac_b_ff <= fprod[FRAC_W-1:0];
         num_c_ff  <= num_b_ff;
         den_c_ff  <= den_b_ff;
         side_c_ff <= '{seg: seg_b_ff, sus: sus_b_ff, wmag: wmag_c_in, wneg: wneg_c_in};
      end
   end

   // ---------------- envelope divider ----------------
   logic              vld_d;
   logic [QUOT_W-1:0] quot_d;
   logic [SIDE_W-1:0] side_d_raw;
   side_type          side_d;

   oasu_div #(
      .DEN_W  (SEG_W),
      .QUOT_W (QUOT_W),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (vld_c_ff),
      .in_num    (num_c_ff),
      .in_den    (den_c_ff),
      .in_side   (side_c_ff),
      .out_valid (vld_d),
      .out_quot  (quot_d),
      .out_side  (side_d_raw)
   );

   assign side_d = side_type'(side_d_raw);

   // ---------------- stage E: envelope level ----------------
   logic [LEVEL_W-1:0] env_e_in;
   logic               vld_e_ff;
   logic [LEVEL_W-1:0] env_e_ff;
   logic [WMAG_W-1:0]  wmag_e_ff;
   logic               wneg_e_ff;

   always_comb begin
      case (side_d.seg)
         SEG_ATTACK:  env_e_in = quot_d;
         SEG_DECAY:   env_e_in = FULL_SCALE - quot_d;
         SEG_SUSTAIN: env_e_in = side_d.sus;
         SEG_RELEASE: env_e_in = quot_d;
         default:     env_e_in = '0;
      endcase
   end

   // ---------------- stage F: gain multiply ----------------
   logic               vld_f_ff;
   logic [LEVEL_W-1:0] env_f_ff;
   logic [LEVEL_W+WMAG_W-1:0] prod_f_ff;
   logic               wneg_f_ff;

   // ---------------- stage G: saturate into the output register ----------------
   logic [LEVEL_W-1:0]  mag_g;
   logic [SAMPLE_W-1:0] sample_g;
   logic [SAMPLE_W-1:0] rsp_sample_ff;
   logic [LEVEL_W-1:0]  rsp_env_ff;

   always_comb begin
      mag_g = prod_f_ff[LEVEL_W+WMAG_W-1:WMAG_W];
      if (wneg_f_ff) begin
         sample_g = SAMPLE_W'(17'd0 - mag_g);
      end else if (mag_g > 17'd32767) begin
         sample_g = 16'd32767;
      end else begin
         sample_g = mag_g[SAMPLE_W-1:0];
      end
   end

   // advance the back stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_e_ff     <= 1'b0;
         vld_f_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_e_ff     <= vld_d;
         vld_f_ff     <= vld_e_ff;
         rsp_valid_ff <= vld_f_ff;
      end
      if (advance) begin
         env_e_ff      <= env_e_in;
         wmag_e_ff     <= side_d.wmag;
         wneg_e_ff     <= side_d.wneg;
         env_f_ff      <= env_e_ff;
         prod_f_ff     <= (LEVEL_W+WMAG_W)'(env_e_ff) * (LEVEL_W+WMAG_W)'(wmag_e_ff);
         wneg_f_ff     <= wneg_e_ff;
         rsp_sample_ff <= sample_g;
         rsp_env_ff    <= env_f_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_env_ff, rsp_sample_ff};

   // ---------------- assertions ----------------
   a_env_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_env_ff <= FULL_SCALE))
      else $error("envelope above full scale");

   a_zero_env_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_env_ff == '0)) |-> (rsp_sample_ff == '0))
      else $error("sample without envelope");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (vld_f_ff && !advance) |=> vld_f_ff)
      else $error("item lost behind a stalled response");

endmodule
